[rtl/core/step_cycle_phase_lookup_macros.svh]
// ============================================================================
// Step cycle phase lookup - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ============================================================================
`ifndef STEP_CYCLE_PHASE_LOOKUP_MACROS_SVH
`define STEP_CYCLE_PHASE_LOOKUP_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define SCPL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define SCPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/scpl_pkg.sv]
// ============================================================================
// Step cycle phase lookup - package
// Shared sizes, item types, codes and helpers for the phase lookup block.
// ============================================================================
package scpl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 15;
    localparam int RD_W    = 14;
    localparam int PHASE_W = 8;
    localparam int SEG_W   = 6;
    localparam int STAT_W  = 2;
    localparam int ENT_W   = 16;
    localparam int CC_W    = 7;
    localparam int CPC_W   = 15;

    // Divider operand widths: offset times 255 and the gradient
    localparam int DVD_W = VAL_W + 8;
    localparam int DSR_W = CPC_W;

    // One encoder turn
    localparam int ONE_TURN = 1 << RD_W;

    // Front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_CYCLE_COUNT      = 1'b0;
    localparam logic REG_COUNTS_PER_CYCLE = 1'b1;

    // Reset values of the registers
    localparam logic [CC_W-1:0]  CYCLE_COUNT_RST      = 7'd50;
    localparam logic [CPC_W-1:0] COUNTS_PER_CYCLE_RST = 15'd327;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_WRITE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOCAL = 2'd2;
    localparam logic [STAT_W-1:0] ST_ORDER = 2'd3;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] entry_value;
        logic [RD_W-1:0]  reading;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [SEG_W-1:0]   segment;
        logic [STAT_W-1:0]  status;
    } t_out_item;

    // Classified job handed from front to back
    typedef struct packed {
        t_op              op;
        logic             wr_ok;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] entry_value;
        logic [RD_W-1:0]  reading;
    } t_job;

    typedef struct packed {
        logic [CC_W-1:0]  cycle_count;
        logic [CPC_W-1:0] counts_per_cycle;
    } t_cfg;

    // Clamp the programmed cycle count to 1..TABLE_DEPTH
    function automatic logic [CNT_W-1:0] active_count(input logic [CC_W-1:0] cc);
        logic [CNT_W-1:0] n;
        if (cc == '0) begin
            n = CNT_W'(1);
        end else if (32'(cc) > TABLE_DEPTH) begin
            n = CNT_W'(TABLE_DEPTH);
        end else begin
            n = CNT_W'(cc);
        end
        return n;
    endfunction

endpackage

[rtl/core/scpl_front.sv]
// ============================================================================
// Step cycle phase lookup - front end
// Accepts request items, classifies them and queues them for the back end.
// ============================================================================
module scpl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  scpl_pkg::t_in_item i_in_item,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output scpl_pkg::t_job    o_job
);
    import scpl_pkg::*;

    t_job              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    t_job              w_job;
    logic              w_push;
    logic              w_pop;

    // Classify the request and flag writes that land inside the table
    always_comb begin
        w_job.op          = i_in_item.req_type ? OP_LOOKUP : OP_WRITE;
        w_job.wr_ok       = (32'(i_in_item.entry_index) < TABLE_DEPTH);
        w_job.entry_index = i_in_item.entry_index;
        w_job.entry_value = i_in_item.entry_value;
        w_job.reading     = i_in_item.reading;
    end

    assign o_in_ready  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_job_valid && i_job_ready;

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold queued jobs
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

[rtl/core/scpl_div.sv]
// ============================================================================
// Step cycle phase lookup - serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module scpl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [scpl_pkg::DVD_W-1:0]  i_dividend,
    input  logic [scpl_pkg::DSR_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [scpl_pkg::DVD_W-1:0]  o_quot
);
    import scpl_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [DSR_W-1:0]  r_dsr;
    logic [DSR_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DSR_W:0]    w_trial;
    logic              w_fits;

    // Shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dsr});

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= STEP_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= w_fits ? DSR_W'(w_trial - {1'b0, r_dsr}) : w_trial[DSR_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[rtl/core/scpl_back.sv]
// ============================================================================
// Step cycle phase lookup - back end
// Holds the calibration table, walks segments, divides and emits results.
// ============================================================================
`include "step_cycle_phase_lookup_macros.svh"

module scpl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scpl_pkg::t_cfg      i_cfg,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  scpl_pkg::t_job      i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output scpl_pkg::t_out_item o_out_item
);
    import scpl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BASE  = 6'b000010,
        S_WALK  = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [ENT_W-1:0]  r_table [TABLE_DEPTH];
    logic [ENT_W-1:0]  r_rdata;
    logic [TABLE_DEPTH-1:0] r_written;
    logic [VAL_W-1:0]  r_rd, n_rd;
    logic [ENT_W-1:0]  r_prev, n_prev;
    logic [ENT_W-1:0]  r_start, n_start;
    logic [TBL_AW-1:0] r_i, n_i;
    logic [TBL_AW-1:0] r_nlast, n_nlast;
    logic [TBL_AW-1:0] r_seg, n_seg;
    t_out_item         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [CNT_W-1:0]       w_n;
    logic [TABLE_DEPTH-1:0] w_mask;
    logic                   w_all_written;
    logic                   w_pop;
    logic                   w_wr_en;
    logic [TBL_AW-1:0]      w_wr_addr;
    logic [TBL_AW-1:0]      w_rd_addr;
    logic [ENT_W-1:0]       w_rd16;
    logic [VAL_W-1:0]       w_off;
    logic [DVD_W-1:0]       w_dividend;
    logic [DSR_W-1:0]       w_divisor;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [DVD_W-1:0]       w_quot;

    // Active entries must all be calibrated before a lookup
    assign w_n = active_count(i_cfg.cycle_count);
    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_mask[k] = (k < 32'(w_n));
        end
    end
    assign w_all_written = &(r_written | ~w_mask);

    assign o_job_ready = (r_state == S_IDLE);
    assign w_pop       = i_job_valid && o_job_ready;
    assign w_wr_addr   = TBL_AW'(i_job.entry_index);
    assign w_rd16      = {1'b0, r_rd};
    assign w_off       = VAL_W'(w_rd16 - r_start);
    assign w_dividend  = {w_off, 8'd0} - {8'd0, w_off};
    assign w_divisor   = (i_cfg.counts_per_cycle == '0) ? DSR_W'(1) : i_cfg.counts_per_cycle;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_rd        = r_rd;
        n_prev      = r_prev;
        n_start     = r_start;
        n_i         = r_i;
        n_nlast     = r_nlast;
        n_seg       = r_seg;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_wr_en     = 1'b0;
        w_rd_addr   = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    if (i_job.op == OP_WRITE) begin
                        w_wr_en         = i_job.wr_ok;
                        n_res.phase     = '0;
                        n_res.segment   = i_job.entry_index;
                        n_res.status    = ST_WRITE;
                        n_state         = S_EMIT;
                    end else if (!w_all_written) begin
                        n_res.phase     = '0;
                        n_res.segment   = '0;
                        n_res.status    = ST_NOCAL;
                        n_state         = S_EMIT;
                    end else begin
                        n_rd    = {1'b0, i_job.reading};
                        n_nlast = TBL_AW'(w_n - CNT_W'(1));
                        n_state = S_BASE;
                    end
                end
            end
            S_BASE: begin
                // Entry 0 is on the read port; wrap readings below it by one turn
                w_rd_addr = TBL_AW'(1);
                if (w_rd16 < r_rdata) begin
                    n_rd = r_rd + VAL_W'(ONE_TURN);
                end
                n_prev = r_rdata;
                n_i    = '0;
                if (r_nlast == '0) begin
                    n_seg   = '0;
                    n_start = r_rdata;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // Entry i+1 is on the read port, entry i held in r_prev
                w_rd_addr = r_i + TBL_AW'(2);
                if (w_rd16 >= r_prev && w_rd16 < r_rdata) begin
                    n_seg   = r_i;
                    n_start = r_prev;
                    n_state = S_CHECK;
                end else if (r_i + TBL_AW'(1) == r_nlast) begin
                    n_seg   = r_nlast;
                    n_start = r_rdata;
                    n_state = S_CHECK;
                end else begin
                    n_prev = r_rdata;
                    n_i    = r_i + TBL_AW'(1);
                end
            end
            S_CHECK: begin
                if (w_rd16 < r_start) begin
                    n_res.phase   = '0;
                    n_res.segment = SEG_W'(r_seg);
                    n_res.status  = ST_ORDER;
                    n_state       = S_EMIT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res.phase   = w_quot[PHASE_W-1:0];
                    n_res.segment = SEG_W'(r_seg);
                    n_res.status  = ST_OK;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                // Load the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_written   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_wr_en) begin
                r_written[w_wr_addr] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd    <= n_rd;
        r_prev  <= n_prev;
        r_start <= n_start;
        r_i     <= n_i;
        r_nlast <= n_nlast;
        r_seg   <= n_seg;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Calibration table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[w_wr_addr] <= {1'b0, i_job.entry_value};
        end
        r_rdata <= r_table[w_rd_addr];
    end

    scpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `SCPL_ASSERT_NEXT(a_div_to_emit, (r_state == S_DIV) && w_div_done, r_state == S_EMIT, "divide result not emitted")
    `SCPL_ASSERT_NEXT(a_write_marks, w_wr_en, r_written[$past(w_wr_addr)], "written bit not set")
    `SCPL_ASSERT_IMPL(a_walk_bound, r_state == S_WALK, r_i < r_nlast, "walk ran past last segment")

endmodule

[rtl/core/step_cycle_phase_lookup.sv]
// Order: a write result goes from the queue through the back end emit state
// to the output register. A lookup passes the queue, a base state, a segment
// walk up to the last active entry, a check state, the serial divider
// (23 quotient bits and a done pulse) and the output register load.
// Throughput: one item at a time in the back end; a two-entry queue takes new
// items meanwhile. Reset clears the written flags and loads 50 and 327.
// ============================================================================
// Step cycle phase lookup - top level
// APB configuration registers, front end queue and back end sequencer.
// ============================================================================
module step_cycle_phase_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  scpl_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output scpl_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpl_pkg::PADDR_W-1:0]  paddr,
    input  logic [scpl_pkg::PDATA_W-1:0]  pwdata,
    output logic [scpl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import scpl_pkg::*;

    logic [CC_W-1:0]  r_cycle_count;
    logic [CPC_W-1:0] r_counts_per_cycle;
    logic             w_reg_idx;
    t_cfg             w_cfg;
    t_job             w_job;
    logic             w_job_valid;
    logic             w_job_ready;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1];

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_count      <= CYCLE_COUNT_RST;
            r_counts_per_cycle <= COUNTS_PER_CYCLE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                REG_CYCLE_COUNT:      r_cycle_count      <= pwdata[CC_W-1:0];
                REG_COUNTS_PER_CYCLE: r_counts_per_cycle <= pwdata[CPC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (w_reg_idx)
            REG_CYCLE_COUNT:      prdata = PDATA_W'(r_cycle_count);
            REG_COUNTS_PER_CYCLE: prdata = PDATA_W'(r_counts_per_cycle);
            default:              prdata = '0;
        endcase
    end

    assign w_cfg.cycle_count      = r_cycle_count;
    assign w_cfg.counts_per_cycle = r_counts_per_cycle;

    scpl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    scpl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
